[rtl/btpt_pkg.sv]
package btpt_pkg;

  localparam int unsigned NodeCountDef = 1024;
  localparam int unsigned ValueBitsDef = 16;
  localparam int unsigned KeyBitsDef   = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_EXACT  = 2'd2,
    CMD_LPM    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRD,
    S_DEV,
    S_BLD,
    S_AL,
    S_ALW,
    S_SRD,
    S_SWT,
    S_SEV,
    S_SP1,
    S_PRUNE,
    S_PWT,
    S_PEV,
    S_FIN
  } state_e;

endpackage

[rtl/binary_trie_prefix_table.sv]
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+------------------------------------------
// request   | start in, busy out            | command, key, prefix_len, value, subtree
// result    | done_o strobe, one cycle      | status, found, result_value, node_count
// config    | cfg_valid_i / cfg_ready_o     | cfg_data_i (key width)
//
// A lookup or add walks the trie one level at a time, with one node memory read per level,
// and ends with a result step.
// Each new node on an add takes its index from the bump pointer, or pops it off the free stack.
// Subtree removal reads each freed node and pushes its children onto the free stack;
// pruning then reads and rewrites each ancestor in turn.
// Reset clears the trie at once; no clearing pass is needed.
// The result strobe cannot be stalled; busy stays high until it has been shown.
module binary_trie_prefix_table import btpt_pkg::*; #(
  parameter int unsigned NODE_COUNT = NodeCountDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command_i,
  input  logic [KEY_BITS-1:0]                key_i,
  input  logic [$clog2(KEY_BITS+1)-1:0]      prefix_len_i,
  input  logic [VALUE_BITS-1:0]              value_i,
  input  logic                               remove_subtree_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [$clog2(KEY_BITS+1)-1:0]      cfg_data_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic                               found_o,
  output logic [VALUE_BITS-1:0]              result_value_o,
  output logic [$clog2(NODE_COUNT+1)-1:0]    node_count_o
);

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned CW = $clog2(NODE_COUNT + 1);
  localparam int unsigned LW = $clog2(KEY_BITS + 1);
  localparam int unsigned PD = KEY_BITS + 1;
  localparam int unsigned XW = ((CW > LW) ? CW : LW) + 1;

  typedef struct packed {
    logic [1:0][NW-1:0]    link;
    logic [1:0]            has;
    logic                  hv;
    logic [VALUE_BITS-1:0] val;
  } node_t;

  localparam int unsigned NodeW = $bits(node_t);

  state_e                state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   ks_q, ks_d;
  logic [LW-1:0]         plen_q, plen_d, lv_q, lv_d, kw_q, kw_d;
  logic [VALUE_BITS-1:0] val_q, val_d, rval_q, rval_d;
  logic                  sub_q, sub_d, found_q, found_d, newroot_q, newroot_d;
  logic                  root_pres_q, root_pres_d, pb_q, pb_d;
  logic [NW-1:0]         cur_q, cur_d, root_q, root_d, p1_q, p1_d;
  node_t                 cr_q, cr_d;
  logic [CW-1:0]         bump_q, bump_d, sp_q, sp_d, sc_q, sc_d;
  status_e               status_q, status_d;

  logic              node_we, fs_we, pa_we;
  logic [NW-1:0]     node_wa, node_ra, fs_wa, fs_ra, fs_wd;
  node_t             node_wd, nd, upd;
  logic [NodeW-1:0]  node_rdata;
  logic [NW-1:0]     fs_rdata;
  logic [LW-1:0]     pa_wa, pa_ra;
  logic [NW:0]       pa_wd, pa_rdata;

  logic [LW-1:0]     kwc, shamt, plen_sat;
  logic [CW-1:0]     used, free_cnt;
  logic              b, alloc_go;
  logic [NW-1:0]     nn;

  btpt_ram #(.WIDTH(NodeW), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_wa), .wdata_i(node_wd),
    .raddr_i(node_ra), .rdata_o(node_rdata)
  );

  btpt_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_free_ram (
    .clk_i, .we_i(fs_we), .waddr_i(fs_wa), .wdata_i(fs_wd),
    .raddr_i(fs_ra), .rdata_o(fs_rdata)
  );

  btpt_ram #(.WIDTH(NW + 1), .DEPTH(PD)) u_path_ram (
    .clk_i, .we_i(pa_we), .waddr_i(pa_wa), .wdata_i(pa_wd),
    .raddr_i(pa_ra), .rdata_o(pa_rdata)
  );

  assign nd       = node_t'(node_rdata);
  assign used     = bump_q - sp_q;
  assign free_cnt = CW'(NODE_COUNT) - used;
  assign b        = ks_q[KEY_BITS-1];

  assign kwc = (kw_q == '0) ? LW'(1) :
               ((kw_q > LW'(KEY_BITS)) ? LW'(KEY_BITS) : kw_q);
  assign shamt    = LW'(KEY_BITS) - kwc;
  assign plen_sat = (prefix_len_i > kwc) ? kwc : prefix_len_i;

  assign busy         = (state_q != S_IDLE);
  assign cfg_ready_o  = (state_q == S_IDLE);
  assign done_o       = (state_q == S_FIN);
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign result_value_o = rval_q;
  assign node_count_o = used;

  always_comb begin
    state_d = state_q;  cmd_d = cmd_q;  ks_d = ks_q;  plen_d = plen_q;
    lv_d = lv_q;  kw_d = kw_q;  val_d = val_q;  rval_d = rval_q;
    sub_d = sub_q;  found_d = found_q;  newroot_d = newroot_q;
    root_pres_d = root_pres_q;  pb_d = pb_q;  cur_d = cur_q;  root_d = root_q;
    p1_d = p1_q;  cr_d = cr_q;  bump_d = bump_q;  sp_d = sp_q;  sc_d = sc_q;
    status_d = status_q;

    node_we = 1'b0;  node_wa = cur_q;  node_wd = cr_q;  node_ra = cur_q;
    fs_we = 1'b0;  fs_wa = sp_q[NW-1:0];  fs_wd = cur_q;  fs_ra = sc_q[NW-1:0];
    pa_we = 1'b0;  pa_wa = lv_q;  pa_wd = {b, cur_q};  pa_ra = lv_q - LW'(1);
    upd = nd;
    alloc_go = 1'b0;
    nn = fs_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          kw_d = cfg_data_i;
        end
        if (start) begin
          cmd_d     = cmd_e'(command_i);
          ks_d      = key_i << shamt;
          plen_d    = plen_sat;
          lv_d      = '0;
          val_d     = value_i;
          sub_d     = remove_subtree_i;
          status_d  = ST_OK;
          found_d   = 1'b0;
          rval_d    = '0;
          newroot_d = 1'b0;
          cur_d     = root_q;
          if (root_pres_q) begin
            state_d = S_DRD;
          end else if (cmd_e'(command_i) == CMD_ADD) begin
            if (XW'(plen_sat) + XW'(1) > XW'(free_cnt)) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              newroot_d = 1'b1;
              state_d   = S_AL;
            end
          end else begin
            status_d = ST_MISS;
            state_d  = S_FIN;
          end
        end
      end

      S_DRD: begin
        node_ra = cur_q;
        state_d = S_DEV;
      end

      S_DEV: begin
        case (cmd_q)
          CMD_LPM: begin
            if (nd.hv) begin
              found_d = 1'b1;
              rval_d  = nd.val;
            end
            if (lv_q == plen_q || !nd.has[b]) begin
              status_d = (found_q || nd.hv) ? ST_OK : ST_MISS;
              state_d  = S_FIN;
            end
          end
          CMD_EXACT: begin
            if (lv_q == plen_q) begin
              found_d  = nd.hv;
              rval_d   = nd.hv ? nd.val : '0;
              status_d = nd.hv ? ST_OK : ST_MISS;
              state_d  = S_FIN;
            end else if (!nd.has[b]) begin
              status_d = ST_MISS;
              state_d  = S_FIN;
            end
          end
          CMD_REMOVE: begin
            pa_we = 1'b1;
            if (lv_q == plen_q) begin
              if (!nd.hv) begin
                status_d = ST_MISS;
                state_d  = S_FIN;
              end else if (sub_q) begin
                fs_we   = 1'b1;
                sc_d    = sp_q;
                sp_d    = sp_q + CW'(1);
                state_d = S_SRD;
              end else begin
                upd.hv  = 1'b0;
                upd.val = '0;
                node_we = 1'b1;
                node_wd = upd;
                if (nd.has == 2'b00) begin
                  fs_we   = 1'b1;
                  sp_d    = sp_q + CW'(1);
                  state_d = S_PRUNE;
                end else begin
                  state_d = S_FIN;
                end
              end
            end else if (!nd.has[b]) begin
              status_d = ST_MISS;
              state_d  = S_FIN;
            end
          end
          default: begin
            if (lv_q == plen_q) begin
              upd.hv  = 1'b1;
              upd.val = val_q;
              node_we = 1'b1;
              node_wd = upd;
              state_d = S_FIN;
            end else if (!nd.has[b]) begin
              if (XW'(plen_q) - XW'(lv_q) > XW'(free_cnt)) begin
                status_d = ST_FULL;
                state_d  = S_FIN;
              end else begin
                cr_d    = nd;
                state_d = S_BLD;
              end
            end
          end
        endcase
        // Walk one level further when the command did not finish here.
        if (state_d == S_DEV) begin
          cur_d   = nd.link[b];
          lv_d    = lv_q + LW'(1);
          ks_d    = ks_q << 1;
          state_d = S_DRD;
        end
      end

      S_BLD: begin
        if (lv_q == plen_q) begin
          upd     = cr_q;
          upd.hv  = 1'b1;
          upd.val = val_q;
          node_we = 1'b1;
          node_wd = upd;
          state_d = S_FIN;
        end else begin
          state_d = S_AL;
        end
      end

      S_AL: begin
        if (sp_q != '0) begin
          fs_ra   = sp_q[NW-1:0] - NW'(1);
          sp_d    = sp_q - CW'(1);
          state_d = S_ALW;
        end else begin
          nn       = bump_q[NW-1:0];
          bump_d   = bump_q + CW'(1);
          alloc_go = 1'b1;
        end
      end

      S_ALW: begin
        nn       = fs_rdata;
        alloc_go = 1'b1;
      end

      S_SRD: begin
        if (sc_q == sp_q) begin
          state_d = S_PRUNE;
        end else begin
          fs_ra   = sc_q[NW-1:0];
          state_d = S_SWT;
        end
      end

      S_SWT: begin
        node_ra = fs_rdata;
        state_d = S_SEV;
      end

      // The free stack above the scan pointer doubles as the work queue of the sweep.
      S_SEV: begin
        sc_d    = sc_q + CW'(1);
        state_d = S_SRD;
        if (nd.has[0]) begin
          fs_we = 1'b1;
          fs_wd = nd.link[0];
          sp_d  = sp_q + CW'(1);
          if (nd.has[1]) begin
            p1_d    = nd.link[1];
            state_d = S_SP1;
          end
        end else if (nd.has[1]) begin
          fs_we = 1'b1;
          fs_wd = nd.link[1];
          sp_d  = sp_q + CW'(1);
        end
      end

      S_SP1: begin
        fs_we   = 1'b1;
        fs_wd   = p1_q;
        sp_d    = sp_q + CW'(1);
        state_d = S_SRD;
      end

      S_PRUNE: begin
        if (lv_q == '0) begin
          root_pres_d = 1'b0;
          state_d     = S_FIN;
        end else begin
          pa_ra   = lv_q - LW'(1);
          state_d = S_PWT;
        end
      end

      S_PWT: begin
        node_ra = pa_rdata[NW-1:0];
        cur_d   = pa_rdata[NW-1:0];
        pb_d    = pa_rdata[NW];
        state_d = S_PEV;
      end

      S_PEV: begin
        upd.has[pb_q] = 1'b0;
        node_we = 1'b1;
        node_wd = upd;
        lv_d    = lv_q - LW'(1);
        if (upd.has == 2'b00 && !upd.hv) begin
          fs_we   = 1'b1;
          sp_d    = sp_q + CW'(1);
          state_d = S_PRUNE;
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A node index has been taken: hang it below the current node or make it the root.
    if (alloc_go) begin
      cr_d    = '0;
      cur_d   = nn;
      state_d = S_BLD;
      if (newroot_q) begin
        root_d      = nn;
        root_pres_d = 1'b1;
        newroot_d   = 1'b0;
      end else begin
        upd         = cr_q;
        upd.link[b] = nn;
        upd.has[b]  = 1'b1;
        node_we     = 1'b1;
        node_wd     = upd;
        lv_d        = lv_q + LW'(1);
        ks_d        = ks_q << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kw_q        <= LW'(KEY_BITS);
      root_pres_q <= 1'b0;
      root_q      <= '0;
      bump_q      <= '0;
      sp_q        <= '0;
      sc_q        <= '0;
      newroot_q   <= 1'b0;
      status_q    <= ST_OK;
      found_q     <= 1'b0;
      rval_q      <= '0;
    end else begin
      state_q     <= state_d;
      kw_q        <= kw_d;
      root_pres_q <= root_pres_d;
      root_q      <= root_d;
      bump_q      <= bump_d;
      sp_q        <= sp_d;
      sc_q        <= sc_d;
      newroot_q   <= newroot_d;
      status_q    <= status_d;
      found_q     <= found_d;
      rval_q      <= rval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ks_q   <= ks_d;
    plen_q <= plen_d;
    lv_q   <= lv_d;
    val_q  <= val_d;
    sub_q  <= sub_d;
    pb_q   <= pb_d;
    cur_q  <= cur_d;
    p1_q   <= p1_d;
    cr_q   <= cr_d;
  end

endmodule

[rtl/btpt_ram.sv]
module btpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/btpt_checker.sv]
module btpt_props import btpt_pkg::*; #(
  parameter int unsigned NODE_COUNT = NodeCountDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            cfg_ready_o,
  input logic                            done_o,
  input logic [1:0]                      status_o,
  input logic                            found_o,
  input logic [VALUE_BITS-1:0]           result_value_o,
  input logic [$clog2(NODE_COUNT+1)-1:0] node_count_o
);

  // Each accepted transaction keeps the block busy at least until its result.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transaction");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == ST_OK))
    else $error("found reported with a failing status");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (result_value_o == '0))
    else $error("nonzero value without a hit");

  a_full_nochange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (node_count_o == $past(node_count_o)))
    else $error("node count changed on a full pool");

endmodule

bind binary_trie_prefix_table btpt_props #(
  .NODE_COUNT(NODE_COUNT),
  .VALUE_BITS(VALUE_BITS),
  .KEY_BITS(KEY_BITS)
) u_btpt_props (.*);

[verif/btpt_checker.sv]
module btpt_checker import btpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] key_i,
  input  logic [5:0]  prefix_len_i,
  input  logic [15:0] value_i,
  input  logic        remove_subtree_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic        found_i,
  input  logic [15:0] result_value_i,
  input  logic [10:0] node_count_i,
  output int          errors_o,
  output int          pending_o,
  output int          full_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Nodes = 1024;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] value;
    logic [10:0] count;
  } lookup_res_t;

  lookup_res_t result_q[$];

  // Shadow copy of the trie and its node pool.
  logic [9:0]  child[2][Nodes];
  bit          has_child[2][Nodes];
  bit          has_val[Nodes];
  logic [15:0] node_val[Nodes];
  int unsigned free_stack[Nodes];
  int unsigned sweep[Nodes];
  int unsigned walk[33];
  int unsigned free_top, used_nodes, root_idx, width_reg;
  bit          root_valid;

  function automatic int unsigned grab_node();
    int unsigned idx;
    idx = free_stack[free_top % Nodes] % Nodes;
    free_top++;
    used_nodes++;
    has_child[0][idx] = 0;
    has_child[1][idx] = 0;
    child[0][idx] = '0;
    child[1][idx] = '0;
    has_val[idx] = 0;
    node_val[idx] = '0;
    return idx;
  endfunction

  function automatic void drop_node(int unsigned idx);
    if (free_top != 0) begin
      free_top--;
      free_stack[free_top % Nodes] = idx % Nodes;
      used_nodes--;
    end
  endfunction

  function automatic void drop_subtree(int unsigned top);
    int unsigned sp, n;
    sweep[0] = top % Nodes;
    sp = 1;
    while (sp > 0) begin
      sp = sp - 1;
      n = sweep[sp];
      for (int c = 0; c < 2; c++) begin
        if (has_child[c][n] && sp < Nodes) begin
          sweep[sp] = child[c][n];
          sp = sp + 1;
        end
      end
      drop_node(n);
    end
  endfunction

  function automatic lookup_res_t trie_apply(cmd_e cmd, logic [31:0] key, int unsigned plen_in,
                                             logic [15:0] val, bit sub);
    lookup_res_t r;
    int unsigned kw, plen, cur, have, need, t, d;
    bit ok, freed, b;
    r = '0;
    r.status = ST_OK;
    kw = (width_reg == 0) ? 1 : (width_reg > 32) ? 32 : width_reg;
    plen = (plen_in > kw) ? kw : plen_in;
    case (cmd)
      CMD_ADD: begin
        have = 0;
        if (root_valid) begin
          have = 1;
          cur = root_idx;
          for (int i = 0; i < plen; i++) begin
            b = key[kw-1-i];
            if (!has_child[b][cur]) break;
            cur = child[b][cur];
            have++;
          end
        end
        need = plen + 1 - have;
        if (need > Nodes - free_top) begin
          r.status = ST_FULL;
        end else begin
          if (!root_valid) begin
            root_idx = grab_node();
            root_valid = 1;
          end
          cur = root_idx;
          for (int i = 0; i < plen; i++) begin
            b = key[kw-1-i];
            if (!has_child[b][cur]) begin
              t = grab_node();
              child[b][cur] = t;
              has_child[b][cur] = 1;
            end
            cur = child[b][cur];
          end
          node_val[cur] = val;
          has_val[cur] = 1;
        end
      end
      CMD_REMOVE: begin
        ok = root_valid;
        if (ok) begin
          walk[0] = root_idx;
          for (int i = 0; i < plen && ok; i++) begin
            b = key[kw-1-i];
            if (!has_child[b][walk[i]]) ok = 0;
            else walk[i+1] = child[b][walk[i]];
          end
        end
        if (ok && !has_val[walk[plen]]) ok = 0;
        if (!ok) begin
          r.status = ST_MISS;
        end else begin
          t = walk[plen];
          freed = 0;
          if (sub) begin
            drop_subtree(t);
            freed = 1;
          end else begin
            has_val[t] = 0;
            node_val[t] = '0;
            if (!has_child[0][t] && !has_child[1][t]) begin
              drop_node(t);
              freed = 1;
            end
          end
          // Free every ancestor that is left with no value and no child.
          if (freed) begin
            d = plen;
            forever begin
              if (d == 0) begin
                root_valid = 0;
                break;
              end
              has_child[key[kw-d]][walk[d-1]] = 0;
              d--;
              if (has_child[0][walk[d]] || has_child[1][walk[d]] || has_val[walk[d]]) break;
              drop_node(walk[d]);
            end
          end
        end
      end
      CMD_EXACT: begin
        ok = root_valid;
        cur = root_idx;
        for (int i = 0; i < plen && ok; i++) begin
          b = key[kw-1-i];
          if (!has_child[b][cur]) ok = 0;
          else cur = child[b][cur];
        end
        if (ok && has_val[cur]) begin
          r.found = 1;
          r.value = node_val[cur];
        end else begin
          r.status = ST_MISS;
        end
      end
      default: begin
        if (root_valid) begin
          cur = root_idx;
          if (has_val[cur]) begin
            r.found = 1;
            r.value = node_val[cur];
          end
          for (int i = 0; i < plen; i++) begin
            b = key[kw-1-i];
            if (!has_child[b][cur]) break;
            cur = child[b][cur];
            if (has_val[cur]) begin
              r.found = 1;
              r.value = node_val[cur];
            end
          end
        end
        if (!r.found) r.status = ST_MISS;
      end
    endcase
    r.count = used_nodes[10:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Nodes; i++) begin
        free_stack[i] = i;
        has_child[0][i] = 0;
        has_child[1][i] = 0;
        has_val[i] = 0;
      end
      free_top = 0;
      used_nodes = 0;
      root_valid = 0;
      root_idx = 0;
      width_reg = 32;
      result_q.delete();
      errors_o = 0;
      pending_o = 0;
      full_seen_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) width_reg = cfg_data_i;
      if (done_i) begin
        if (result_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result, status %0d found %0d value %0h count %0d",
                   $time, status_i, found_i, result_value_i, node_count_i);
        end else begin
          want = result_q.pop_front();
          if (status_i !== want.status || found_i !== want.found ||
              result_value_i !== want.value || node_count_i !== want.count) begin
            errors_o++;
            $display("%0t: expected status %0d found %0d value %0h count %0d, got %0d %0d %0h %0d",
                     $time, want.status, want.found, want.value, want.count,
                     status_i, found_i, result_value_i, node_count_i);
          end
          if (want.status == ST_FULL) full_seen_o++;
        end
      end
      if (start_i && !busy_i)
        result_q.push_back(trie_apply(cmd_e'(command_i), key_i, prefix_len_i, value_i,
                                      remove_subtree_i));
      pending_o = result_q.size();
    end
  end
endmodule

[verif/tb.sv]
module tb import btpt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  command_i = CMD_LPM;
  logic [31:0] key_i = '0;
  logic [5:0]  prefix_len_i = '0;
  logic [15:0] value_i = '0;
  logic        remove_subtree_i = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i = '0;
  logic        done_o, found_o;
  logic [1:0]  status_o;
  logic [15:0] result_value_o;
  logic [10:0] node_count_o;
  int          errors, pending, full_seen;

  int unsigned idle_pct, width_now, sent;
  logic [31:0] known_key[$];
  int unsigned known_len[$];

  always #4 clk_i = ~clk_i;

  binary_trie_prefix_table u_top (
    .clk_i, .rst_ni, .start, .busy, .command_i, .key_i, .prefix_len_i, .value_i,
    .remove_subtree_i, .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o, .status_o,
    .found_o, .result_value_o, .node_count_o
  );

  btpt_checker u_chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .key_i, .prefix_len_i,
    .value_i, .remove_subtree_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .done_i(done_o), .status_i(status_o), .found_i(found_o),
    .result_value_i(result_value_o), .node_count_i(node_count_o),
    .errors_o(errors), .pending_o(pending), .full_seen_o(full_seen)
  );

  task automatic issue(cmd_e cmd, logic [31:0] key, int unsigned plen, logic [15:0] val,
                       bit sub);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1;
    command_i <= cmd;
    key_i <= key;
    prefix_len_i <= plen[5:0];
    value_i <= val;
    remove_subtree_i <= sub;
    do @(posedge clk_i); while (busy);
    sent++;
    if (cmd == CMD_ADD && known_key.size() < 64) begin
      known_key.push_back(key);
      known_len.push_back(plen);
    end
  endtask

  task automatic set_width(logic [5:0] w);
    start <= 0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    width_now = (w == 0) ? 1 : (w > 32) ? 32 : w;
    known_key.delete();
    known_len.delete();
  endtask

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, width_now);
  endfunction

  task automatic random_item();
    int unsigned r, k;
    bit reuse;
    logic [31:0] key;
    int unsigned plen;
    r = $urandom_range(0, 99);
    reuse = known_key.size() > 0 && $urandom_range(0, 9) < 8;
    k = (known_key.size() > 0) ? $urandom_range(0, known_key.size() - 1) : 0;
    key = reuse ? known_key[k] : $urandom();
    plen = reuse ? known_len[k] : pick_len();
    if (r < 35) begin
      if ($urandom_range(0, 9) < 7) begin
        key = $urandom();
        plen = pick_len();
      end
      issue(CMD_ADD, key, plen, 16'($urandom_range(0, 65535)), 0);
    end else if (r < 60) begin
      issue(CMD_REMOVE, key, plen, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      if (reuse) begin
        known_key.delete(k);
        known_len.delete(k);
      end
    end else if (r < 80) begin
      issue(CMD_EXACT, key, plen, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end else begin
      // Key with the bits below its top plen bits randomized, looked up with a fresh prefix length.
      issue(CMD_LPM, key ^ ($urandom() >> plen), pick_len(), 16'($urandom_range(0, 65535)),
            1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [5:0] widths[7] = '{6'd32, 6'd0, 6'd5, 6'd63, 6'd1, 6'd17, 6'd32};
    idle_pct = 37;
    width_now = 32;
    sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Empty table, then the field extremes and each miss and prune case.
    issue(CMD_LPM, '1, 32, '0, 0);
    issue(CMD_REMOVE, '0, 0, '0, 1);
    issue(CMD_EXACT, '0, 0, '0, 0);
    issue(CMD_ADD, '0, 0, 16'hFFFF, 0);
    issue(CMD_ADD, '1, 32, 16'h0000, 0);
    issue(CMD_ADD, 32'h0, 63, 16'h1234, 0);
    issue(CMD_ADD, 32'hF000_0000, 4, 16'hAAAA, 1);
    issue(CMD_EXACT, '1, 32, '0, 0);
    issue(CMD_EXACT, '1, 5, '0, 0);
    issue(CMD_LPM, '1, 63, '0, 0);
    issue(CMD_LPM, 32'hF0F0_F0F0, 32, '0, 0);
    issue(CMD_LPM, 32'h5555_5555, 32, '0, 0);
    issue(CMD_REMOVE, '1, 7, '0, 0);
    issue(CMD_REMOVE, '1, 32, '0, 0);
    issue(CMD_ADD, '1, 32, 16'h5A5A, 0);
    issue(CMD_ADD, 32'hF000_0000, 4, 16'hBBBB, 0);
    issue(CMD_REMOVE, 32'hF000_0000, 4, '0, 1);
    issue(CMD_EXACT, '0, 32, '0, 0);
    issue(CMD_REMOVE, '0, 0, '0, 0);
    issue(CMD_REMOVE, '0, 32, '0, 1);
    issue(CMD_LPM, '0, 32, '0, 0);

    foreach (widths[p]) begin
      set_width(widths[p]);
      idle_pct = (p < 2) ? 37 : (p < 5) ? 87 : 0;
      issue(CMD_ADD, $urandom(), 0, 16'h0001, 0);
      repeat (155) random_item();
      // Clear the table from the root so the next width starts small.
      issue(CMD_ADD, '0, 0, 16'h0002, 0);
      issue(CMD_REMOVE, '0, 0, '0, 1);
    end

    start <= 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d requests over 7 key width settings, including 0 and 63.", sent);
    $display("Pool exhaustion was hit %0d times; add, remove, exact and LPM all mixed.",
             full_seen);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[sim.f]
rtl/btpt_pkg.sv
rtl/btpt_ram.sv
rtl/binary_trie_prefix_table.sv
rtl/btpt_checker.sv
verif/btpt_checker.sv
verif/tb.sv
